// ===== src/dq_pkg.sv =====
package dq_pkg;

    // element and result field widths, and the default capacity
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    // operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic              en;
        t_op               op;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

// ===== src/dq_if.sv =====
// request channel: one operation per beat
interface dq_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic signed [dq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// result channel: deque state after each operation
interface dq_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dq_pkg::DATA_W-1:0]  front_value;
    logic signed [dq_pkg::DATA_W-1:0]  back_value;
    logic [dq_pkg::OCC_W-1:0]          occupancy;
    logic                              is_empty;
    logic                              failed;

    modport source (output valid, output front_value, output back_value,
                    output occupancy, output is_empty, output failed, input ready);
    modport sink   (input valid, input front_value, input back_value,
                    input occupancy, input is_empty, input failed, output ready);
endinterface

// ===== src/dq_cell.sv =====
module dq_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  dq_pkg::t_cell_cmd         i_cmd,
    input  logic [dq_pkg::DATA_W-1:0] i_left_data,
    input  logic                      i_left_valid,
    input  logic [dq_pkg::DATA_W-1:0] i_right_data,
    input  logic                      i_right_valid,
    output logic [dq_pkg::DATA_W-1:0] o_data,
    output logic                      o_valid,
    output logic [dq_pkg::DATA_W-1:0] o_back
);

    logic [dq_pkg::DATA_W-1:0] r_data;
    logic [dq_pkg::DATA_W-1:0] n_data;
    logic                      r_valid;
    logic                      n_valid;

    // next contents: shift toward the back, shift toward the front, or act at the tail
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_cmd.en) begin
            case (i_cmd.op)
                dq_pkg::OP_PUSH_FRONT: begin
                    n_data  = i_left_data;
                    n_valid = i_left_valid;
                end
                dq_pkg::OP_POP_FRONT: begin
                    n_data  = i_right_data;
                    n_valid = i_right_valid;
                end
                dq_pkg::OP_PUSH_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        n_data  = i_cmd.value;
                        n_valid = 1'b1;
                    end
                end
                dq_pkg::OP_POP_BACK: begin
                    if (r_valid && !i_right_valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // this cell is the back when it holds data and its right neighbor does not
    assign o_back  = (r_valid && !i_right_valid) ? r_data : '0;
    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

// ===== src/double_ended_queue_top.sv =====
// double-ended queue of CAPACITY signed 32-bit elements
//
// i_in carries one operation per beat: push back, push front, pop back or
// pop front, with the value to push. o_out returns one beat per request
// with the front and back elements, the occupancy, an empty flag and a
// failed flag (push when full, pop when empty; the contents stay as they
// were). Front and back read as zero while the deque is empty.
//
// The elements sit in a chain of CAPACITY cells, front at cell 0. Pushes
// and pops at the front shift the whole chain by one cell, operations at
// the back act at the end of the occupied run. An accepted operation
// updates the chain and sets a pending flag; its result is then registered
// onto o_out once o_out can load. One request per cycle is sustained while
// o_out drains. When the receiver stalls, one operation can complete in the
// chain while the previous result waits; after that i_in.ready drops until
// o_out moves. Reset empties the deque, clears the pending flag and
// o_out.valid; with no clearing pass, requests are taken right after reset.
module double_ended_queue_top #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dq_in_if.sink     i_in,
    dq_out_if.source  o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    dq_pkg::t_cell_cmd          cmd;
    logic [dq_pkg::DATA_W-1:0]  cell_data  [CAPACITY];
    logic [dq_pkg::DATA_W-1:0]  cell_back  [CAPACITY];
    logic [CAPACITY-1:0]        cell_valid;
    logic [dq_pkg::DATA_W-1:0]  back_sel;

    logic                       full;
    logic                       empty;
    logic                       is_push;
    logic                       fail;
    logic                       in_acc;
    logic                       can_load;

    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              n_cnt;
    logic                       r_pend;
    logic                       r_pend_fail;
    logic                       r_out_valid;
    logic [dq_pkg::DATA_W-1:0]  r_front;
    logic [dq_pkg::DATA_W-1:0]  r_back;
    logic [dq_pkg::OCC_W-1:0]   r_occ;
    logic                       r_empty;
    logic                       r_fail;
    logic [CW+dq_pkg::OCC_W-1:0] cnt_ext;

    // request decode and error check
    assign full     = cell_valid[CAPACITY-1];
    assign empty    = !cell_valid[0];
    assign is_push  = (i_in.op == dq_pkg::OP_PUSH_BACK) ||
                      (i_in.op == dq_pkg::OP_PUSH_FRONT);
    assign fail     = is_push ? full : empty;
    assign can_load = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_pend || can_load;
    assign in_acc   = i_in.valid && i_in.ready;

    assign cmd.en    = in_acc && !fail;
    assign cmd.op    = dq_pkg::t_op'(i_in.op);
    assign cmd.value = i_in.value;

    // the chain: cell 0 sees the incoming value as an always-valid left neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [dq_pkg::DATA_W-1:0] left_data;
        logic                      left_valid;
        logic [dq_pkg::DATA_W-1:0] right_data;
        logic                      right_valid;

        if (g == 0) begin : g_first
            assign left_data  = i_in.value;
            assign left_valid = 1'b1;
        end else begin : g_mid_l
            assign left_data  = cell_data[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid_r
            assign right_data  = cell_data[g+1];
            assign right_valid = cell_valid[g+1];
        end

        dq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .i_left_data   (left_data),
            .i_left_valid  (left_valid),
            .i_right_data  (right_data),
            .i_right_valid (right_valid),
            .o_data        (cell_data[g]),
            .o_valid       (cell_valid[g]),
            .o_back        (cell_back[g])
        );
    end

    // at most one cell flags itself as the back
    always_comb begin
        back_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            back_sel = back_sel | cell_back[k];
        end
    end

    // occupancy counter
    always_comb begin
        n_cnt = r_cnt;
        if (cmd.en) begin
            if (is_push) begin
                n_cnt = r_cnt + CW'(1);
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    assign cnt_ext = (CW + dq_pkg::OCC_W)'(r_cnt);

    // control: counter, pending flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_pend <= 1'b1;
            end else if (r_pend && can_load) begin
                r_pend <= 1'b0;
            end
            if (r_pend && can_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result beat, taken from the chain once the operation is in it and o_out can load
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pend_fail <= fail;
        end
        if (r_pend && can_load) begin
            r_front <= cell_valid[0] ? cell_data[0] : '0;
            r_back  <= back_sel;
            r_occ   <= cnt_ext[dq_pkg::OCC_W-1:0];
            r_empty <= !cell_valid[0];
            r_fail  <= r_pend_fail;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.front_value = r_front;
    assign o_out.back_value  = r_back;
    assign o_out.occupancy   = r_occ;
    assign o_out.is_empty    = r_empty;
    assign o_out.failed      = r_fail;

    // counter agrees with the number of occupied cells
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == CW'($countones(cell_valid)))
        else $error("occupancy counter disagrees with occupied cells");

    // occupied cells form an unbroken run from the front
    a_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot({1'b0, cell_valid} + (CAPACITY + 1)'(1)))
        else $error("gap in occupied cells");

    // a failed operation leaves the counter alone
    a_fail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && fail) |=> $stable(r_cnt))
        else $error("failed operation changed occupancy");

    // an empty result reads zero at both ends
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_front == '0 && r_back == '0))
        else $error("empty result with nonzero front or back");

    // no second result is taken from the chain while one is still unsent
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_out_valid && !o_out.ready) |=> r_pend)
        else $error("pending result dropped while output stalled");

endmodule

// ===== tb/sv/double_ended_queue_top_tb.sv =====
`timescale 1ns / 1ps

module double_ended_queue_top_tb;

    localparam int          DEPTH        = dq_pkg::CAPACITY_DEF;
    localparam int          DW           = dq_pkg::DATA_W;
    localparam int          OW           = dq_pkg::OCC_W;
    localparam int          RANDOM_ITEMS = 1425;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          STALL_LIMIT  = 1000;
    localparam int          END_WAIT     = 10;
    localparam logic [31:0] VAL_MAX      = 32'h7fff_ffff;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;

    // how a burst of random operations leans
    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } t_burst_mode;

    // deque state as reported after one operation
    typedef struct {
        logic [DW-1:0] front_value;
        logic [DW-1:0] back_value;
        logic [OW-1:0] occupancy;
        logic          is_empty;
        logic          failed;
    } t_deque_view;

    // mirror of the deque contents plus the views still owed by the block
    class deque_mirror;
        logic [DW-1:0] ring [DEPTH];
        int unsigned   head;
        int unsigned   tail;
        int unsigned   count;
        t_deque_view   owed_views [$];
        int unsigned   mismatches;

        function new();
            foreach (ring[i]) ring[i] = '0;
            head       = 0;
            tail       = 0;
            count      = 0;
            mismatches = 0;
        endfunction

        // apply one accepted request and queue the view it must produce
        function void apply_op(dq_pkg::t_op op, logic [DW-1:0] value);
            t_deque_view view;
            view.failed = 1'b0;
            case (op)
                dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
                    if (count >= DEPTH) begin
                        view.failed = 1'b1;
                    end else begin
                        if (count != 0) begin
                            if (op == dq_pkg::OP_PUSH_BACK) tail = (tail + 1) % DEPTH;
                            else head = (head + DEPTH - 1) % DEPTH;
                        end
                        if (op == dq_pkg::OP_PUSH_BACK) ring[tail] = value;
                        else                            ring[head] = value;
                        count++;
                    end
                end
                dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
                    if (count == 0) begin
                        view.failed = 1'b1;
                    end else begin
                        count--;
                        if (count != 0) begin
                            if (op == dq_pkg::OP_POP_BACK) tail = (tail + DEPTH - 1) % DEPTH;
                            else head = (head + 1) % DEPTH;
                        end
                    end
                end
            endcase
            view.front_value = (count != 0) ? ring[head] : '0;
            view.back_value  = (count != 0) ? ring[tail] : '0;
            view.occupancy   = OW'(count);
            view.is_empty    = (count == 0);
            owed_views.push_back(view);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                         $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare one result beat with the oldest owed view
        function void compare_view(t_deque_view got);
            t_deque_view want;
            if (owed_views.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %0d/%0d/%0d",
                         $time, $signed(got.front_value), $signed(got.back_value),
                         got.occupancy);
                mismatches++;
            end else begin
                want = owed_views.pop_front();
                check_field("front_value", want.front_value, got.front_value);
                check_field("back_value", want.back_value, got.back_value);
                check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                check_field("failed", 32'(want.failed), 32'(got.failed));
            end
        endfunction

        function int unsigned pending();
            return owed_views.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    bit          no_idle;
    bit          hold_req;
    deque_mirror mirror;

    dq_in_if  in_ch ();
    dq_out_if out_ch ();

    double_ended_queue_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // beat monitor: feed accepted requests and check accepted results
    always @(posedge i_clk) begin
        t_deque_view got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                mirror.apply_op(dq_pkg::t_op'(in_ch.op), in_ch.value);
            end
            if (out_ch.valid && out_ch.ready) begin
                got.front_value = out_ch.front_value;
                got.back_value  = out_ch.back_value;
                got.occupancy   = out_ch.occupancy;
                got.is_empty    = out_ch.is_empty;
                got.failed      = out_ch.failed;
                mirror.compare_view(got);
            end
        end
    end

    // result receiver: random stalls, quiet stretch, one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (no_idle) begin
                out_ch.ready = 1'b1;
            end else begin
                out_ch.ready = ($urandom_range(99) >= 24);
            end
        end
    end

    // no-progress watchdog
    initial begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one request beat; entered and left at a falling edge
    task automatic send_op(dq_pkg::t_op op, logic [DW-1:0] value);
        while (!no_idle && $urandom_range(99) < 24) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.op    = op;
        in_ch.value = value;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // stop offering until every owed result has come back
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (mirror.pending() != 0) @(negedge i_clk);
    endtask

    function automatic dq_pkg::t_op pick_op(t_burst_mode mode);
        int unsigned push_pct;
        case (mode)
            MODE_FILL:  push_pct = 85;
            MODE_DRAIN: push_pct = 15;
            default:    push_pct = 50;
        endcase
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
        return $urandom_range(1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
    endfunction

    function automatic logic [DW-1:0] pick_value();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return '1;
                2:       return VAL_MAX;
                default: return VAL_MIN;
            endcase
        end
        return $urandom;
    endfunction

    // main sequence
    initial begin
        t_burst_mode mode;
        int unsigned burst_left;
        mirror       = new();
        i_rst_n      = 1'b0;
        no_idle      = 1'b0;
        hold_req     = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.op     = dq_pkg::OP_PUSH_BACK;
        in_ch.value  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pops on an empty deque, both ends
        send_op(dq_pkg::OP_POP_BACK, VAL_MAX);
        send_op(dq_pkg::OP_POP_FRONT, '1);
        // extreme values, front push wraps the index backward
        send_op(dq_pkg::OP_PUSH_BACK, VAL_MAX);
        send_op(dq_pkg::OP_PUSH_FRONT, VAL_MIN);
        send_op(dq_pkg::OP_POP_BACK, '0);
        send_op(dq_pkg::OP_POP_FRONT, '0);
        // fill to capacity from both ends, then push into a full deque
        for (int i = 0; i < DEPTH; i++) begin
            send_op((i % 2) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                    (i == 0) ? '0 : (i == 1) ? '1 : 32'(i * 32'h1357_9bdf));
        end
        send_op(dq_pkg::OP_PUSH_BACK, 32'h5a5a_5a5a);
        send_op(dq_pkg::OP_PUSH_FRONT, 32'ha5a5_a5a5);

        // random bursts leaning toward full, toward empty or neither
        burst_left = 0;
        mode       = MODE_MIXED;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) wait_drained();
            if (n == 500) hold_req = 1'b1;
            if (n == 800) no_idle = 1'b1;
            if (n == 1000) no_idle = 1'b0;
            if (burst_left == 0) begin
                mode       = t_burst_mode'($urandom_range(2));
                burst_left = $urandom_range(40, 8);
            end
            burst_left--;
            send_op(pick_op(mode), pick_value());
        end

        wait_drained();
        repeat (END_WAIT) @(negedge i_clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue_top.f =====
src/dq_pkg.sv
src/dq_if.sv
src/dq_cell.sv
src/double_ended_queue_top.sv
tb/sv/double_ended_queue_top_tb.sv
